### hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TSPP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define TSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/tspp_pkg.sv
// Shared constants and types of the tilted scan point projection core.
package tspp_pkg;

    // Polynomial sine coefficients (Q30 fixed point).
    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [29:0] SIN_B = 30'd688904866;
    localparam logic [26:0] SIN_C = 27'd76016977;

    localparam logic [15:0] QUARTER_TURN = 16'd16384;

    // Register indexes of the configuration port.
    localparam logic [7:0] REG_RANGE_MIN   = 8'd0;
    localparam logic [7:0] REG_RANGE_MAX   = 8'd1;
    localparam logic [7:0] REG_START_ANGLE = 8'd2;
    localparam logic [7:0] REG_ANGLE_STEP  = 8'd3;

    // Fields that travel alongside the arithmetic.
    typedef struct packed {
        logic        valid;
        logic [15:0] range;
        logic [15:0] intensity;
        logic        last;
    } sideband_t;

endpackage

### hw/rtl/tspp_sin.sv
// Four-cell pipelined Q15 sine of a 16-bit binary angle.
module tspp_sin
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        angle,
    output logic signed [16:0] sine
);

    logic [14:0]        u_fold;
    logic [29:0]        usq;

    logic [14:0]        u1_reg, u2c_reg, u3_reg;
    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [30:0]        u2_1_reg, u2_2_reg;
    logic [29:0]        inner_reg;
    logic [30:0]        outer_reg;
    logic signed [16:0] sine_reg;

    logic [57:0]        p_full;
    logic [29:0]        inner_next;
    logic [60:0]        q_full;
    logic [30:0]        outer_next;
    logic [45:0]        m_full;
    logic [16:0]        mag;

    assign u_fold = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
    assign usq    = 30'(u_fold) * 30'(u_fold);

    assign p_full     = 58'(u2_1_reg) * 58'(tspp_pkg::SIN_C);
    assign inner_next = tspp_pkg::SIN_B - {2'b00, p_full[57:30]};

    assign q_full     = 61'(u2_2_reg) * 61'(inner_reg);
    assign outer_next = tspp_pkg::SIN_A - {1'b0, q_full[59:30]};

    assign m_full = 46'(u3_reg) * 46'(outer_reg);
    assign mag    = m_full[45:29];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg    <= u_fold;
            neg1_reg  <= angle[15];
            u2_1_reg  <= {usq[28:0], 2'b00};

            u2c_reg   <= u1_reg;
            neg2_reg  <= neg1_reg;
            u2_2_reg  <= u2_1_reg;
            inner_reg <= inner_next;

            u3_reg    <= u2c_reg;
            neg3_reg  <= neg2_reg;
            outer_reg <= outer_next;

            sine_reg  <= neg3_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign sine = sine_reg;

endmodule

### hw/rtl/tilted_scan_point_projection_core.sv
// Tilted scan point projection: one laser beam in, one 3D point out.
//
// Input channel (in_valid/in_stall): one beam per transfer with index,
// range, intensity, roll angle and last-beam mark. Beams whose range is not
// strictly between range_minimum and range_maximum give no point.
// Output channel (out_valid/out_stall): one point per kept beam, in order.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; index 0..3 writes range min, range max, start angle, angle
// step; other indexes are ignored. Write only while the block is idle.
// Throughput: one beam per cycle while the pipeline advances. A beam passes
// from input transfer to out_valid through the angle multiply, four sine
// cells, two product cells and the output register.
// The whole pipeline advances unless a result waits in the output register
// under out_stall; in_stall is raised exactly then.
// Reset clears all valid bits and loads the register defaults
// (range max 65535, all others 0).
module tilted_scan_point_projection_core
#(
    parameter int INDEX_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [INDEX_BITS-1:0] beam_index,
    input  logic [15:0]           beam_range,
    input  logic [15:0]           beam_intensity,
    input  logic signed [15:0]    roll_angle,
    input  logic                  last_beam,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [16:0]    point_x,
    output logic signed [16:0]    point_y,
    output logic signed [16:0]    point_z,
    output logic [15:0]           point_intensity,
    output logic                  point_last,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    logic [15:0] range_min_reg, range_max_reg, start_angle_reg, angle_step_reg;

    logic                       adv;
    logic                       keep;
    logic [15+INDEX_BITS:0]     step_prod;

    logic [15:0]                ang_reg;
    logic [15:0]                roll_reg;
    tspp_pkg::sideband_t        sb1_reg;
    tspp_pkg::sideband_t        sb_reg [0:3];

    logic signed [16:0]         ca, sa, cr, sr;

    logic signed [33:0]         xp_reg, xp2_reg, rs_reg;
    logic signed [16:0]         cr_reg, sr_reg;
    tspp_pkg::sideband_t        sbp1_reg, sbp2_reg;
    logic signed [50:0]         yp_reg, zp_reg;

    logic signed [33:0]         x_adj;
    logic signed [50:0]         y_adj, z_adj;
    logic signed [33:0]         x_sh;
    logic signed [50:0]         y_sh, z_sh;

    logic                       out_valid_reg;
    logic signed [16:0]         x_reg, y_reg, z_reg;
    logic [15:0]                inten_reg;
    logic                       last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg   <= 16'd0;
            range_max_reg   <= 16'hFFFF;
            start_angle_reg <= 16'd0;
            angle_step_reg  <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tspp_pkg::REG_RANGE_MIN:   range_min_reg   <= cfg_data;
                tspp_pkg::REG_RANGE_MAX:   range_max_reg   <= cfg_data;
                tspp_pkg::REG_START_ANGLE: start_angle_reg <= cfg_data;
                tspp_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    assign keep      = (range_min_reg < beam_range) && (beam_range < range_max_reg);
    assign step_prod = (16+INDEX_BITS)'(angle_step_reg) * (16+INDEX_BITS)'(beam_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb1_reg  <= '0;
            sbp1_reg <= '0;
            sbp2_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                sb_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            sb1_reg.valid     <= in_valid && keep;
            sb1_reg.range     <= beam_range;
            sb1_reg.intensity <= beam_intensity;
            sb1_reg.last      <= last_beam;
            sb_reg[0]         <= sb1_reg;
            for (int i = 1; i < 4; i++)
            begin
                sb_reg[i] <= sb_reg[i-1];
            end
            sbp1_reg <= sb_reg[3];
            sbp2_reg <= sbp1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang_reg  <= start_angle_reg + step_prod[15:0];
            roll_reg <= roll_angle;
        end
    end

    tspp_sin u_cos_a  (.clk(clk), .en(adv), .angle(ang_reg + tspp_pkg::QUARTER_TURN),
                       .sine(ca));
    tspp_sin u_sin_a  (.clk(clk), .en(adv), .angle(ang_reg), .sine(sa));
    tspp_sin u_cos_r  (.clk(clk), .en(adv), .angle(roll_reg + tspp_pkg::QUARTER_TURN),
                       .sine(cr));
    tspp_sin u_sin_r  (.clk(clk), .en(adv), .angle(roll_reg), .sine(sr));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xp_reg  <= $signed({1'b0, sb_reg[3].range}) * ca;
            rs_reg  <= $signed({1'b0, sb_reg[3].range}) * sa;
            cr_reg  <= cr;
            sr_reg  <= sr;
            xp2_reg <= xp_reg;
            yp_reg  <= rs_reg * cr_reg;
            zp_reg  <= rs_reg * sr_reg;
        end
    end

    // Round toward zero: bias negatives before the arithmetic shift.
    assign x_adj = xp2_reg + (xp2_reg[33] ? 34'sd32767 : 34'sd0);
    assign y_adj = yp_reg + (yp_reg[50] ? 51'sd1073741823 : 51'sd0);
    assign z_adj = zp_reg + (zp_reg[50] ? 51'sd1073741823 : 51'sd0);
    assign x_sh  = x_adj >>> 15;
    assign y_sh  = y_adj >>> 30;
    assign z_sh  = z_adj >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sbp2_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg     <= x_sh[16:0];
            y_reg     <= y_sh[16:0];
            z_reg     <= z_sh[16:0];
            inten_reg <= sbp2_reg.intensity;
            last_reg  <= sbp2_reg.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign point_x         = x_reg;
    assign point_y         = y_reg;
    assign point_z         = z_reg;
    assign point_intensity = inten_reg;
    assign point_last      = last_reg;

endmodule

### hw/rtl/tspp_checker.sv
// Port-level checker for the projection core, with its bind.
`include "assert_macros.svh"

module tspp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [16:0] point_x,
    input logic               cfg_valid,
    input logic               cfg_ready
);

    `TSPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output dropped under stall")
    `TSPP_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(point_x), "payload moved")
    `TSPP_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled needlessly")
    `TSPP_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind tilted_scan_point_projection_core tspp_checker u_tspp_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .point_x(point_x),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
);
